// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the speed controller RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, disabled while reset is held low
`define PSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define PSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/core/psc_pkg.sv -----
`default_nettype none

package psc_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] CFG_KP_GAIN        = 3'd0;
    localparam logic [2:0] CFG_KI_GAIN        = 3'd1;
    localparam logic [2:0] CFG_KD_GAIN        = 3'd2;
    localparam logic [2:0] CFG_OUTPUT_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_INTEGRAL_LIMIT = 3'd4;

    // Reset value of both magnitude limits
    localparam logic [14:0] LIMIT_RESET = 15'h7FFF;

    // Live configuration, as seen by the datapath
    typedef struct packed {
        logic signed [15:0] kp_gain;
        logic signed [15:0] ki_gain;
        logic signed [15:0] kd_gain;
        logic [14:0]        output_limit;
        logic [14:0]        integral_limit;
    } t_cfg;

    // Product stage to summing stage; all terms carry 8 fraction bits
    typedef struct packed {
        logic signed [32:0] p_term;
        logic signed [32:0] i_prod;
        logic signed [33:0] d_term;
    } t_prod;

endpackage

`default_nettype wire

// ----- rtl/core/pid_speed_controller_unit.sv -----
// PID speed controller: one drive value for every speed sample.
//
// Input stream: each transfer on the slave side carries a measured and a
// target speed. Output stream: each transfer on the master side carries
// one clamped drive value. Results leave in the order samples arrive.
// Output tvalid rises once a sample has passed the input register, gain
// product register and result register. One sample is taken per cycle
// unless the receiver stalls with all stages full; the integral feedback
// closes within the result stage.
// Every stage has its own valid bit and fills a bubble ahead of it, so
// a stalled result still lets up to two further samples in; when the
// receiver holds tready low with all stages full, s_tready falls.
// Configuration: write gains and limits on the cfg channel (always ready)
// while the stream is idle. Index 0 kp, 1 ki, 2 kd (signed Q8.8),
// 3 output limit, 4 integral limit (integer units); others are ignored.
// Reset (synchronous, active low) empties the pipeline, zeroes the gains,
// the previous error and the integral, and sets both limits to 32767.
`default_nettype none

module pid_speed_controller_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // Sample stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [15:0] measured, [31:16] target
    // Drive stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [15:0] drive
);

    psc_pkg::t_cfg      cfg;
    psc_pkg::t_prod     prod;
    logic               prod_valid;
    logic               prod_ready;
    logic signed [15:0] drive;

    assign o_cfg_ready = 1'b1;

    psc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    psc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_measured ($signed(i_s_tdata[15:0])),
        .i_target   ($signed(i_s_tdata[31:16])),
        .o_valid    (prod_valid),
        .i_ready    (prod_ready),
        .o_prod     (prod)
    );

    psc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_prod  (prod),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_drive (drive)
    );

    assign o_m_tdata = drive;

endmodule

`default_nettype wire

// ----- rtl/core/psc_cfg.sv -----
`default_nettype none

module psc_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    output psc_pkg::t_cfg      o_cfg
);

    logic signed [15:0] r_kp;
    logic signed [15:0] r_ki;
    logic signed [15:0] r_kd;
    logic [14:0]        r_out_lim;
    logic [14:0]        r_int_lim;

    // Take a register write on each transfer; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_out_lim <= psc_pkg::LIMIT_RESET;
            r_int_lim <= psc_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                psc_pkg::CFG_KP_GAIN:        r_kp      <= i_cfg_data;
                psc_pkg::CFG_KI_GAIN:        r_ki      <= i_cfg_data;
                psc_pkg::CFG_KD_GAIN:        r_kd      <= i_cfg_data;
                psc_pkg::CFG_OUTPUT_LIMIT:   r_out_lim <= i_cfg_data[14:0];
                psc_pkg::CFG_INTEGRAL_LIMIT: r_int_lim <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.kp_gain        = r_kp;
    assign o_cfg.ki_gain        = r_ki;
    assign o_cfg.kd_gain        = r_kd;
    assign o_cfg.output_limit   = r_out_lim;
    assign o_cfg.integral_limit = r_int_lim;

endmodule

`default_nettype wire

// ----- rtl/core/psc_front.sv -----
`default_nettype none
`include "assert_macros.svh"

module psc_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire psc_pkg::t_cfg       i_cfg,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic signed [15:0]  i_measured,
    input  wire logic signed [15:0]  i_target,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output psc_pkg::t_prod           o_prod
);

    logic               r_s1_valid;
    logic signed [15:0] r_measured;
    logic signed [15:0] r_target;
    logic               r_s2_valid;
    psc_pkg::t_prod     r_prod;
    psc_pkg::t_prod     n_prod;
    logic signed [16:0] r_last_err;
    logic signed [16:0] n_err;
    logic signed [17:0] n_diff;
    logic               s2_ready;
    logic               s1_load;
    logic               s2_load;

    // Each stage loads when empty or when its content moves on
    assign s2_ready = !r_s2_valid || i_ready;
    assign o_ready  = !r_s1_valid || s2_ready;
    assign s1_load  = i_valid && o_ready;
    assign s2_load  = r_s1_valid && s2_ready;

    // Hold the input sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_measured <= i_measured;
            r_target   <= i_target;
        end
    end

    // Error, difference and the three gain products
    always_comb begin
        n_err         = 17'(r_target) - 17'(r_measured);
        n_diff        = 18'(n_err) - 18'(r_last_err);
        n_prod.p_term = 33'(i_cfg.kp_gain) * 33'(n_err);
        n_prod.i_prod = 33'(i_cfg.ki_gain) * 33'(n_err);
        n_prod.d_term = 34'(i_cfg.kd_gain) * 34'(n_diff);
    end

    // Advance to the product register; the error becomes the previous error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_last_err <= '0;
        end else begin
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s2_load) begin
                r_last_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_prod  = r_prod;

    // A stalled product stage keeps its products
    `PSC_ASSERT(a_prod_hold, i_clk, i_rst_n,
                r_s2_valid && !i_ready |=> $stable(r_prod),
                "product stage changed while stalled")

endmodule

`default_nettype wire

// ----- rtl/core/psc_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module psc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire psc_pkg::t_cfg  i_cfg,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire psc_pkg::t_prod i_prod,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic signed [15:0]  o_drive
);

    logic               r_out_valid;
    logic signed [15:0] r_drive;
    logic signed [24:0] r_integral;
    logic signed [24:0] n_integral;
    logic signed [33:0] int_raw;
    logic signed [35:0] sum_raw;
    logic signed [24:0] sum_clamped;
    logic               load;

    // Clamp to +/- lim * 256
    function automatic logic signed [24:0] clamp_mag(input logic signed [35:0] v,
                                                     input logic [14:0] lim);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        logic signed [35:0] res;
        hi = $signed({13'd0, lim, 8'd0});
        lo = -hi;
        if (v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v;
        end
        return res[24:0];
    endfunction

    assign o_ready = !r_out_valid || i_ready;
    assign load    = i_valid && o_ready;

    // Integral update, full sum and output clamp
    always_comb begin
        if (i_cfg.ki_gain != 16'sd0) begin
            int_raw = 34'(r_integral) + 34'($signed(i_prod.i_prod));
        end else begin
            int_raw = 34'(r_integral);
        end
        n_integral  = clamp_mag(36'(int_raw), i_cfg.integral_limit);
        sum_raw     = 36'($signed(i_prod.p_term)) + 36'(n_integral)
                    + 36'($signed(i_prod.d_term));
        sum_clamped = clamp_mag(sum_raw, i_cfg.output_limit);
    end

    // Advance the result register and the integral on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_integral  <= '0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (load) begin
                r_integral <= n_integral;
            end
        end
    end

    // Floor shift by the fraction bits; the clamp keeps it within 16 bits
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_drive <= sum_clamped[23:8];
        end
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

    `PSC_ASSERT(a_int_bound, i_clk, i_rst_n,
                load |=> (r_integral <= $signed({10'd0, i_cfg.integral_limit, 8'd0}))
                    && (r_integral >= -$signed({10'd0, i_cfg.integral_limit, 8'd0})),
                "integral outside its limit")
    `PSC_ASSERT(a_drive_bound, i_clk, i_rst_n,
                r_out_valid |-> (17'(r_drive) <= $signed({2'd0, i_cfg.output_limit}))
                    && (17'(r_drive) >= -$signed({2'd0, i_cfg.output_limit})),
                "drive outside output limit")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;

    localparam int FRAC_BITS       = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 10;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 75;

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_GAPS,
        FLOW_RECEIVER_STALLS,
        FLOW_BOTH
    } t_flow_mode;

    // Shadow of the controller: gains, limits, previous error and integral
    class t_drive_scoreboard;
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
        logic [14:0]        out_limit;
        logic [14:0]        int_limit;
        logic signed [16:0] prev_error;
        logic signed [24:0] integral;
        logic [15:0]        drive_q[$];
        int                 errors;
        int                 checked;

        function new();
            kp         = '0;
            ki         = '0;
            kd         = '0;
            out_limit  = psc_pkg::LIMIT_RESET;
            int_limit  = psc_pkg::LIMIT_RESET;
            prev_error = '0;
            integral   = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        function void write_reg(input logic [2:0] index, input logic [15:0] data);
            case (index)
                psc_pkg::CFG_KP_GAIN:        kp = data;
                psc_pkg::CFG_KI_GAIN:        ki = data;
                psc_pkg::CFG_KD_GAIN:        kd = data;
                psc_pkg::CFG_OUTPUT_LIMIT:   out_limit = data[14:0];
                psc_pkg::CFG_INTEGRAL_LIMIT: int_limit = data[14:0];
                default: ;
            endcase
        endfunction

        function longint clamp_mag(input longint v, input longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // Advance the PID state by one sample and queue the drive it gives
        function void note_sample(input logic signed [15:0] measured,
                                  input logic signed [15:0] target);
            longint err;
            longint diff;
            longint acc;
            longint total;
            err  = longint'(target) - longint'(measured);
            diff = err - longint'(prev_error);
            acc  = longint'(integral);
            if (ki != 0) acc += longint'(ki) * err;
            acc   = clamp_mag(acc, longint'(int_limit) <<< FRAC_BITS);
            total = longint'(kp) * err + acc + longint'(kd) * diff;
            total = clamp_mag(total, longint'(out_limit) <<< FRAC_BITS);
            // arithmetic shift of a signed value floors
            drive_q.push_back(16'(total >>> FRAC_BITS));
            integral   = 25'(acc);
            prev_error = 17'(err);
        endfunction

        task check_drive(input logic [15:0] got);
            logic [15:0] want;
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("drive %0d with no sample waiting",
                                          $signed(got)));
            end else begin
                want = drive_q.pop_front();
                checked++;
                if (got !== want)
                    report_mismatch($sformatf("drive got %0d want %0d",
                                              $signed(got), $signed(want)));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // [15:0] measured, [31:16] target
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;   // [15:0] drive

    t_drive_scoreboard sb = new();
    t_flow_mode        flow = FLOW_FREE;
    int                idle_cycles = 0;
    int                samples = 0;
    int                reg_writes = 0;
    int                settings = 0;

    pid_speed_controller_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic bit sender_gap();
        case (flow)
            FLOW_SENDER_GAPS: return $urandom_range(99) < 54;
            FLOW_BOTH:        return $urandom_range(99) < 33;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (flow)
            FLOW_RECEIVER_STALLS: return $urandom_range(99) < 54;
            FLOW_BOTH:            return $urandom_range(99) < 33;
            default:              return 1'b0;
        endcase
    endfunction

    // Mostly moderate gains so the loop stays out of saturation
    function automatic logic [15:0] pick_gain();
        int g;
        if ($urandom_range(3) == 0) return 16'($urandom);
        g = $urandom_range(2048) - 1024;
        return 16'(g);
    endfunction

    // Bit 15 of a limit write is junk and must be dropped by the block
    function automatic logic [15:0] pick_limit();
        logic [14:0] lim;
        case ($urandom_range(3))
            0:       lim = psc_pkg::LIMIT_RESET;
            1:       lim = 15'($urandom);
            2:       lim = 15'($urandom_range(2000));
            default: lim = 15'($urandom_range(100));
        endcase
        return {1'($urandom), lim};
    endfunction

    // Check drive values on every output transfer and toss tready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_drive(o_m_tdata);
        i_m_tready <= !receiver_stall();
    end

    // End the run if nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Hold valid until the register transfer; valid stays up for the next one
    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(index, data);
        reg_writes++;
    endtask

    task automatic program_regs(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] kd, input logic [15:0] olim,
                                input logic [15:0] ilim);
        write_reg(psc_pkg::CFG_KP_GAIN, kp);
        write_reg(psc_pkg::CFG_KI_GAIN, ki);
        write_reg(psc_pkg::CFG_KD_GAIN, kd);
        write_reg(psc_pkg::CFG_OUTPUT_LIMIT, olim);
        write_reg(psc_pkg::CFG_INTEGRAL_LIMIT, ilim);
        // unmapped index: must leave every register alone
        if ($urandom_range(1))
            write_reg(3'($urandom_range(int'(psc_pkg::CFG_INTEGRAL_LIMIT) + 1,
                                        (1 << $bits(i_cfg_index)) - 1)),
                      16'($urandom));
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // Optional gap, then hold the sample until its transfer
    task automatic send_sample(input logic signed [15:0] measured,
                               input logic signed [15:0] target);
        if (sender_gap()) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while (sender_gap());
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {target, measured};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_sample(measured, target);
        samples++;
    endtask

    // Drop valid and wait for every outstanding drive value
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.drive_q.size() != 0);
    endtask

    initial begin
        logic signed [15:0] tgt;
        int                 delta;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: zero gains, full limits
        send_sample(16'sd100, -16'sd200);
        send_sample(-16'sd32768, 16'sd32767);

        // Extreme gains and speeds
        drain_results();
        program_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd21845, -16'sd21846);

        // Integral ramps into a tight limit, then reverses
        drain_results();
        program_regs(16'h0100, 16'h0020, 16'hFF80, 16'd1000, 16'd50);
        repeat (5) send_sample(16'sd0, 16'sd100);
        repeat (2) send_sample(16'sd300, -16'sd200);

        // Frozen integral still clamped by a lowered limit
        drain_results();
        program_regs(16'h0100, 16'h0000, 16'h0040, 16'h7FFF, 16'd3);
        send_sample(16'sd10, 16'sd20);
        send_sample(16'sd20, 16'sd10);
        send_sample(16'sd0, 16'sd0);

        // Zero output limit forces the drive to zero
        drain_results();
        program_regs(16'h0100, 16'h0000, 16'h0040, 16'h0000, 16'd3);
        send_sample(16'sd5, -16'sd5);
        send_sample(-16'sd32768, 16'sd32767);

        // Random phases, one flow mode each
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            flow = t_flow_mode'(p % 4);
            case (p)
                0: program_regs(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
                1: program_regs(16'h8000, 16'h8000, 16'h8000, 16'd1, 16'd0);
                3: program_regs(pick_gain(), 16'h0000, pick_gain(),
                                pick_limit(), pick_limit());
                default: program_regs(pick_gain(), pick_gain(), pick_gain(),
                                      pick_limit(), pick_limit());
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2) drain_results();
                tgt = 16'($urandom);
                if ($urandom_range(9) < 6) begin
                    // tracking: measured close to target
                    delta = $urandom_range(600) - 300;
                    send_sample(16'(tgt - 16'(delta)), tgt);
                end else begin
                    send_sample(16'($urandom), tgt);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.drive_q.size() != 0)
            sb.report_mismatch($sformatf("%0d drive values never arrived",
                                         sb.drive_q.size()));
        $display("Sent %0d speed samples over %0d gain/limit settings (%0d writes),",
                 samples, settings, reg_writes);
        $display("%s; %0d drives checked, %0d errors.",
                 "with free flow, sender gaps, receiver stalls and both",
                 sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
